### design/gspd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspd_pkg: shared types and constants of the gain-scheduled PID drive
// Sequencer states, divider control/status and fixed-point constants.
// ----------------------------------------------------------------------------
package gspd_pkg;

  // Widths of the shared multiplier and the back-calculation divider
  localparam int MUL_W  = 33;
  localparam int PROD_W = 64;
  localparam int DIV_W  = 64;
  localparam int DEN_W  = 32;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_KP            = 3'd0,
    REG_KI            = 3'd1,
    REG_KD            = 3'd2,
    REG_KP_MULT_HI    = 3'd3,
    REG_KP_MULT_LO    = 3'd4,
    REG_KI_MULT_HI    = 3'd5,
    REG_KI_MULT_LO    = 3'd6,
    REG_SAMPLE_PERIOD = 3'd7
  } cfg_reg_t;

  // Error sign memory codes
  localparam logic [1:0] SIGN_ZERO = 2'd0;
  localparam logic [1:0] SIGN_POS  = 2'd1;
  localparam logic [1:0] SIGN_NEG  = 2'd2;

  // Fixed-point constants (Q16.16 unless noted)
  localparam int INTEGRAL_LIMIT = 200;
  localparam logic signed [32:0] INT_LIM = 33'(INTEGRAL_LIMIT * 65536);
  localparam logic signed [31:0] VENT_THRESHOLD = -32'sd655;
  localparam logic [31:0] MAG_LOW  = 32'd131072;   // 2.0
  localparam logic [31:0] MAG_HIGH = 32'd3276800;  // 50.0
  // ceil(2^24 / 3): exact divide by three for values below 2^23
  localparam logic [MUL_W-1:0] RECIP3 = MUL_W'(5592406);
  // 8000.0 in Q.32
  localparam logic signed [63:0] DRIVE_TOP = 64'sd8000 <<< 32;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SC_DIFF,
    S_SC_RECIP,
    S_SC_SEL,
    S_SC_GAIN,
    S_SC_STORE,
    S_MUL_D,
    S_MUL_INC,
    S_MUL_P,
    S_ADD_P,
    S_MUL_I,
    S_ADD_I,
    S_V_CHECK,
    S_V_ROLL,
    S_N_CLAMP,
    S_DIV_WAIT,
    S_N_ACC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### design/gspd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspd_div: unsigned restoring divider
// One quotient bit per cycle; quotient valid with the done pulse.
// ----------------------------------------------------------------------------
module gspd_div (
  input  logic                        clk,
  input  logic                        rst,
  input  gspd_pkg::div_ctrl_t         ctrl,
  input  logic [gspd_pkg::DIV_W-1:0]  dividend,
  input  logic [gspd_pkg::DEN_W-1:0]  divisor,
  output gspd_pkg::div_stat_t         stat,
  output logic [gspd_pkg::DIV_W-1:0]  quotient
);
  import gspd_pkg::*;

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [DCNT_W-1:0] count;
  logic              busy;
  logic              done;
  logic [DEN_W:0]    shifted;
  logic [DEN_W:0]    trial;
  logic              fits;

  // Trial subtract of one dividend bit
  always_comb begin
    shifted = {rem, quotient[DIV_W-1]};
    trial   = shifted - {1'b0, den};
    fits    = (shifted >= {1'b0, den});
  end

  // Control: count the bit steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy  <= 1'b1;
        count <= DCNT_W'(DIV_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift quotient bits in behind the dividend
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### design/gain_scheduled_pid_drive.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gain_scheduled_pid_drive: gain-scheduled PID valve drive
// Two integrators, error-scheduled Kp/Ki and back-calculation anti-windup.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on item_valid/item_ready with error, derivative (Q16.16),
//   venting and clear_integrators. Each request yields one drive value
//   (Q13.16, 0..8000) on drive_valid/drive_ready.
//   Configuration writes use cfg_valid/cfg_ready with cfg_index/cfg_data;
//   cfg_ready is always high and writes belong in idle periods.
//   One 33x33 multiplier is reused by a sequencer; vent mode may add a
//   rollback step, and finishes early with a zero drive when the error is
//   not below its threshold. When the normal-mode sum saturates with
//   back-calculation, the sequencer waits for the 64-step restoring divider.
//   item_ready is high only while the sequencer is idle, which it enters
//   at the same clock edge that loads the result into the output register.
//   A finished drive value sits in the output register; a new request can
//   be accepted while it waits, and the next result is held in the
//   sequencer until the receiver takes the previous one.
//   Reset loads the default gains and clears both integrators, the sign
//   memory and drive_valid.
// ----------------------------------------------------------------------------
module gain_scheduled_pid_drive (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic signed [31:0] error,
  input  logic signed [31:0] derivative,
  input  logic               venting,
  input  logic               clear_integrators,
  output logic               drive_valid,
  input  logic               drive_ready,
  output logic [28:0]        drive
);
  import gspd_pkg::*;

  // Configuration
  logic [23:0] kp, ki, kd;
  logic [19:0] kp_mult_hi, kp_mult_lo, ki_mult_hi, ki_mult_lo;
  logic [15:0] sample_period;

  // Controller state
  logic signed [31:0] charge_integral;
  logic signed [31:0] vent_accumulator;
  logic [1:0]         last_error_sign;

  // Working registers
  state_t                    state, state_next;
  logic signed [31:0]        e_r, d_r;
  logic                      vent_r;
  logic [31:0]               mag;
  logic                      gsel;
  logic                      diff_neg;
  logic [19:0]               s_r;
  logic [27:0]               kpe, kie;
  logic signed [PROD_W-1:0]  prod;
  logic signed [63:0]        sum, ysum;
  logic signed [31:0]        inc, vent_new;
  logic                      div_sub;
  logic [28:0]               drive_fin;

  // Shared multiplier
  logic signed [MUL_W-1:0]   ma, mb;
  logic signed [2*MUL_W-1:0] mprod;
  logic                      mul_en;

  div_ctrl_t        div_ctrl;
  div_stat_t        div_stat;
  logic [DIV_W-1:0] div_q;
  logic [DEN_W-1:0] div_den;

  // Schedule helpers
  logic [19:0] sc_low, sc_high, abs_diff, sc_q, sc_s;
  logic [21:0] sc_t;
  logic [23:0] gain_sel;
  logic        back_calc;
  logic signed [63:0] clamp_y, num_y;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic [28:0] drive_of(input logic signed [63:0] y);
    logic signed [63:0] c;
    c = y;
    if (y > DRIVE_TOP) c = DRIVE_TOP;
    if (y < 64'sd0) c = 64'sd0;
    return c[44:16];
  endfunction

  assign cfg_ready  = 1'b1;
  assign item_ready = (state == S_IDLE);

  // Scheduling arithmetic for the gain under work
  always_comb begin
    sc_low   = gsel ? ki_mult_lo : kp_mult_lo;
    sc_high  = gsel ? ki_mult_hi : kp_mult_hi;
    gain_sel = gsel ? ki : kp;
    abs_diff = (sc_high >= sc_low) ? sc_high - sc_low : sc_low - sc_high;
    sc_t     = 22'(mag - MAG_LOW);
    sc_q     = prod[43:24];
    if (mag > MAG_HIGH) sc_s = sc_high;
    else if (mag < MAG_LOW) sc_s = sc_low;
    else if (diff_neg) sc_s = sc_low - sc_q;
    else sc_s = sc_low + sc_q;
  end

  // Normal-mode clamp and back-calculation setup
  always_comb begin
    clamp_y   = ysum;
    num_y     = 64'sd0;
    back_calc = 1'b0;
    if (ysum > DRIVE_TOP) begin
      clamp_y   = DRIVE_TOP;
      num_y     = ysum - DRIVE_TOP;
      back_calc = (e_r > 32'sd0) && (kie != '0);
    end else if (ysum < -DRIVE_TOP) begin
      clamp_y   = -DRIVE_TOP;
      num_y     = -(ysum + DRIVE_TOP);
      back_calc = (e_r < 32'sd0) && (kie != '0);
    end
  end

  assign div_den = DEN_W'({kie, 3'b000}) + DEN_W'({kie, 1'b0});

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (item_valid) state_next = S_SC_DIFF;
      S_SC_DIFF:  state_next = S_SC_RECIP;
      S_SC_RECIP: state_next = S_SC_SEL;
      S_SC_SEL:   state_next = S_SC_GAIN;
      S_SC_GAIN:  state_next = S_SC_STORE;
      S_SC_STORE: state_next = gsel ? S_MUL_D : S_SC_DIFF;
      S_MUL_D:    state_next = S_MUL_INC;
      S_MUL_INC:  state_next = S_MUL_P;
      S_MUL_P:    state_next = S_ADD_P;
      S_ADD_P:    state_next = (vent_r && !(e_r < VENT_THRESHOLD)) ? S_DONE : S_MUL_I;
      S_MUL_I:    state_next = S_ADD_I;
      S_ADD_I:    state_next = vent_r ? S_V_CHECK : S_N_CLAMP;
      S_V_CHECK:  state_next = (ysum > DRIVE_TOP) ? S_V_ROLL : S_DONE;
      S_V_ROLL:   state_next = S_DONE;
      S_N_CLAMP:  state_next = back_calc ? S_DIV_WAIT : S_N_ACC;
      S_DIV_WAIT: if (div_stat.done) state_next = S_N_ACC;
      S_N_ACC:    state_next = S_DONE;
      S_DONE:     if (!drive_valid || drive_ready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Multiplier operands and divider start
  always_comb begin
    ma             = '0;
    mb             = '0;
    mul_en         = 1'b1;
    div_ctrl.start = 1'b0;
    unique case (state)
      S_SC_DIFF: begin
        ma = MUL_W'(abs_diff);
        mb = MUL_W'(sc_t);
      end
      S_SC_RECIP: begin
        ma = MUL_W'(prod[41:20]);
        mb = RECIP3;
      end
      S_SC_GAIN: begin
        ma = MUL_W'(gain_sel);
        mb = MUL_W'(s_r);
      end
      S_MUL_D: begin
        ma = MUL_W'(kd);
        mb = MUL_W'(d_r);
      end
      S_MUL_INC: begin
        ma = MUL_W'(e_r);
        mb = MUL_W'(sample_period);
      end
      S_MUL_P: begin
        ma = MUL_W'(kpe);
        mb = vent_r ? $signed({1'b0, mag}) : MUL_W'(e_r);
      end
      S_MUL_I: begin
        ma = MUL_W'(kie);
        mb = vent_r ? MUL_W'(vent_new) : MUL_W'(charge_integral);
      end
      S_V_CHECK: begin
        ma = MUL_W'(kie);
        mb = MUL_W'(vent_accumulator);
      end
      S_N_CLAMP: begin
        mul_en         = 1'b0;
        div_ctrl.start = back_calc;
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mprod = ma * mb;

  always_ff @(posedge clk) begin
    if (mul_en) prod <= mprod[PROD_W-1:0];
  end

  gspd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (num_y),
    .divisor  (div_den),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kp            <= 24'd655360;
      ki            <= 24'd655360;
      kd            <= 24'd327680;
      kp_mult_hi    <= 20'd131072;
      kp_mult_lo    <= 20'd32768;
      ki_mult_hi    <= 20'd131072;
      ki_mult_lo    <= 20'd45875;
      sample_period <= 16'd6554;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KP:            kp            <= cfg_data;
        REG_KI:            ki            <= cfg_data;
        REG_KD:            kd            <= cfg_data;
        REG_KP_MULT_HI:    kp_mult_hi    <= cfg_data[19:0];
        REG_KP_MULT_LO:    kp_mult_lo    <= cfg_data[19:0];
        REG_KI_MULT_HI:    ki_mult_hi    <= cfg_data[19:0];
        REG_KI_MULT_LO:    ki_mult_lo    <= cfg_data[19:0];
        REG_SAMPLE_PERIOD: sample_period <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      charge_integral  <= '0;
      vent_accumulator <= '0;
      last_error_sign  <= SIGN_ZERO;
      drive_valid      <= 1'b0;
      gsel             <= 1'b0;
    end else begin
      state <= state_next;
      // present a finished result, drop it once taken
      if (state == S_DONE && (!drive_valid || drive_ready)) drive_valid <= 1'b1;
      else if (drive_ready) drive_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          gsel <= 1'b0;
          // clear before the step is computed
          if (item_valid && clear_integrators) begin
            charge_integral  <= '0;
            vent_accumulator <= '0;
            last_error_sign  <= SIGN_ZERO;
          end
        end
        S_SC_STORE: gsel <= ~gsel;
        S_MUL_P: begin
          // reset the integral on a sign change in normal mode
          if (!vent_r) begin
            if ((e_r > 32'sd0 && last_error_sign == SIGN_NEG) ||
                (e_r < 32'sd0 && last_error_sign == SIGN_POS))
              charge_integral <= '0;
            if (e_r > 32'sd0) last_error_sign <= SIGN_POS;
            else if (e_r < 32'sd0) last_error_sign <= SIGN_NEG;
            else last_error_sign <= SIGN_ZERO;
          end
        end
        S_ADD_P: begin
          if (vent_r && !(e_r < VENT_THRESHOLD)) vent_accumulator <= '0;
        end
        S_V_CHECK: begin
          if (!(ysum > DRIVE_TOP)) vent_accumulator <= vent_new;
        end
        S_DIV_WAIT: begin
          if (div_stat.done) begin
            if (div_sub)
              charge_integral <= sat32(66'(charge_integral) - $signed({2'b00, div_q}));
            else
              charge_integral <= sat32(66'(charge_integral) + $signed({2'b00, div_q}));
          end
        end
        S_N_ACC: begin
          // accumulate unless pushing further into saturation
          if ((ysum < DRIVE_TOP || e_r <= 32'sd0) && (ysum > 64'sd0 || e_r >= 32'sd0)) begin
            if (33'(charge_integral) + 33'(inc) > INT_LIM)
              charge_integral <= INT_LIM[31:0];
            else if (33'(charge_integral) + 33'(inc) < -INT_LIM)
              charge_integral <= 32'(-INT_LIM);
            else
              charge_integral <= charge_integral + inc;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        e_r    <= error;
        d_r    <= derivative;
        vent_r <= venting;
        mag    <= (error < 32'sd0) ? 32'(-33'(error)) : error;
      end
      S_SC_DIFF:  diff_neg <= (sc_high < sc_low);
      S_SC_SEL:   s_r <= sc_s;
      S_SC_STORE: begin
        if (gsel) kie <= prod[43:16];
        else kpe <= prod[43:16];
      end
      S_MUL_INC:  sum <= prod;
      S_MUL_P:    inc <= prod[47:16];
      S_ADD_P: begin
        sum       <= sum + prod;
        vent_new  <= sat32(66'(vent_accumulator) + 66'(inc));
        drive_fin <= '0;
      end
      S_ADD_I:    ysum <= vent_r ? sum - prod : sum + prod;
      S_V_CHECK:  drive_fin <= drive_of(ysum);
      S_V_ROLL:   drive_fin <= drive_of(sum - prod);
      S_N_CLAMP: begin
        ysum    <= clamp_y;
        div_sub <= (ysum > DRIVE_TOP);
      end
      S_N_ACC:    drive_fin <= drive_of(ysum);
      S_DONE: begin
        if (!drive_valid || drive_ready) drive <= drive_fin;
      end
      default: ;
    endcase
  end

  // Checks
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> (state == S_SC_DIFF))
    else $error("accepted request did not start the schedule");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    drive_valid |-> (drive <= 29'd524288000))
    else $error("drive out of range");

  a_div_alive: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_WAIT) |-> (div_stat.busy || div_stat.done))
    else $error("waiting on an idle divider");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!drive_valid || drive_ready)) |=> drive_valid)
    else $error("finished result not presented");

  a_vent_sign: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD_P && vent_r) |-> $stable(last_error_sign))
    else $error("vent mode touched the sign memory");

endmodule

### tb/gain_scheduled_pid_drive_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gain_scheduled_pid_drive_checker: drive value predictor and scoreboard
// Watches the configuration, request and drive channels. It keeps its own
// copy of the gains and both integrators, predicts each drive value, and
// compares every delivered value against the oldest prediction.
// ----------------------------------------------------------------------------
module gain_scheduled_pid_drive_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               item_valid,
  input  logic               item_ready,
  input  logic signed [31:0] error,
  input  logic signed [31:0] derivative,
  input  logic               venting,
  input  logic               clear_integrators,
  input  logic               drive_valid,
  input  logic               drive_ready,
  input  logic [28:0]        drive,
  output int                 fail_count,
  output int                 pending
);
  import gspd_pkg::*;

  // Gain registers as the block should hold them
  logic [23:0] g_kp, g_ki, g_kd;
  logic [19:0] g_kp_hi, g_kp_lo, g_ki_hi, g_ki_lo;
  logic [15:0] g_period;

  // Integrator state
  logic signed [31:0] charge_acc;
  logic signed [31:0] vent_acc;
  logic [1:0]         err_sign;

  logic [28:0] drive_q[$];

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Gain scale interpolated between the low and high error magnitudes
  function automatic longint gain_scale(longint lo, longint hi, longint mag);
    if (mag > (64'sd50 <<< 16)) return hi;
    if (mag < (64'sd2 <<< 16)) return lo;
    return lo + (hi - lo) * (mag - (64'sd2 <<< 16)) / (64'sd48 <<< 16);
  endfunction

  // Advance the integrators by one request and return the drive value
  function automatic logic [28:0] next_drive(longint e, longint d, logic vent,
                                             logic clr);
    longint top, mag, kpe, kie, dterm, inc, y, p, acc, lim;
    logic signed [31:0] prior;
    top = 64'sd8000 <<< 32;
    lim = 64'(INTEGRAL_LIMIT) * 65536;
    if (clr) begin
      charge_acc = '0;
      vent_acc   = '0;
      err_sign   = SIGN_ZERO;
    end
    mag   = (e < 0) ? -e : e;
    kpe   = (longint'(g_kp) * gain_scale(longint'(g_kp_lo), longint'(g_kp_hi), mag)) >>> 16;
    kie   = (longint'(g_ki) * gain_scale(longint'(g_ki_lo), longint'(g_ki_hi), mag)) >>> 16;
    dterm = longint'(g_kd) * d;
    inc   = (e * longint'(g_period)) >>> 16;
    if (vent) begin
      if (e < longint'(VENT_THRESHOLD)) begin
        p = kpe * mag;
        prior = vent_acc;
        vent_acc = 32'(clip32(longint'(prior) + inc));
        // roll back when the new accumulator would push the drive past 8000
        if (p - kie * longint'(vent_acc) + dterm > top) vent_acc = prior;
        y = p - kie * longint'(vent_acc) + dterm;
        if (y > top) y = top;
        if (y < 0) y = 0;
      end else begin
        vent_acc = '0;
        y = 0;
      end
    end else begin
      // drop the integral on a sign change
      if ((e > 0 && err_sign == SIGN_NEG) || (e < 0 && err_sign == SIGN_POS))
        charge_acc = '0;
      err_sign = (e > 0) ? SIGN_POS : ((e < 0) ? SIGN_NEG : SIGN_ZERO);
      y = kpe * e + kie * longint'(charge_acc) + dterm;
      if (y > top) begin
        if (e > 0 && kie != 0)
          charge_acc = 32'(clip32(longint'(charge_acc) - (y - top) / (kie * 10)));
        y = top;
      end else if (y < -top) begin
        if (e < 0 && kie != 0)
          charge_acc = 32'(clip32(longint'(charge_acc) - (y + top) / (kie * 10)));
        y = -top;
      end
      if (y < 0) y = 0;
      // accumulate only when not pushing further into saturation
      if ((y < top || e <= 0) && (y > 0 || e >= 0)) begin
        acc = longint'(charge_acc) + inc;
        if (acc > lim) acc = lim;
        if (acc < -lim) acc = -lim;
        charge_acc = 32'(clip32(acc));
      end
    end
    return 29'(y >>> 16);
  endfunction

  always @(posedge clk) begin
    logic [28:0] want;
    if (rst) begin
      g_kp = 24'd655360; g_ki = 24'd655360; g_kd = 24'd327680;
      g_kp_hi = 20'd131072; g_kp_lo = 20'd32768;
      g_ki_hi = 20'd131072; g_ki_lo = 20'd45875;
      g_period = 16'd6554;
      charge_acc = '0;
      vent_acc   = '0;
      err_sign   = SIGN_ZERO;
      fail_count = 0;
      drive_q.delete();
    end else begin
      // track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_KP:            g_kp     = cfg_data;
          REG_KI:            g_ki     = cfg_data;
          REG_KD:            g_kd     = cfg_data;
          REG_KP_MULT_HI:    g_kp_hi  = cfg_data[19:0];
          REG_KP_MULT_LO:    g_kp_lo  = cfg_data[19:0];
          REG_KI_MULT_HI:    g_ki_hi  = cfg_data[19:0];
          REG_KI_MULT_LO:    g_ki_lo  = cfg_data[19:0];
          REG_SAMPLE_PERIOD: g_period = cfg_data[15:0];
          default: ;
        endcase
      end
      // compare the delivered drive value
      if (drive_valid && drive_ready) begin
        if (drive_q.size() == 0) begin
          $error("unexpected drive value %0d", drive);
          fail_count++;
        end else begin
          want = drive_q.pop_front();
          if (drive !== want) begin
            $error("drive mismatch: expected %0d actual %0d", want, drive);
            fail_count++;
          end
        end
      end
      // predict the drive value for each accepted request
      if (item_valid && item_ready)
        drive_q.push_back(next_drive(longint'(error), longint'(derivative), venting,
                                     clear_integrators));
    end
    pending = drive_q.size();
  end

endmodule

### tb/gain_scheduled_pid_drive_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gain_scheduled_pid_drive_tb: stimulus for the gain-scheduled PID drive
// Runs directed corner requests and random request streams under several
// gain settings, with bursty requests, receiver stalls and back-pressure.
// ----------------------------------------------------------------------------
module gain_scheduled_pid_drive_tb;
  import gspd_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [23:0]        cfg_data = '0;
  logic               item_valid = 1'b0;
  logic               item_ready;
  logic signed [31:0] error = '0;
  logic signed [31:0] derivative = '0;
  logic               venting = 1'b0;
  logic               clear_integrators = 1'b0;
  logic               drive_valid;
  logic               drive_ready = 1'b0;
  logic [28:0]        drive;
  int                 fail_count;
  int                 pending;
  int                 hold_asked = 0;
  int                 hold_served = 0;

  gain_scheduled_pid_drive u_top (.*);

  gain_scheduled_pid_drive_checker u_checker (.*);

  // Clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: stall pattern, with a long hold-off on request
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_served < hold_asked) begin
        drive_ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_served++;
      end else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: drive_ready = 1'b1;
          1: drive_ready = ($urandom_range(0, 3) != 0);
          2: drive_ready = ($urandom_range(0, 3) == 0);
          default: drive_ready = ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  // Hold the request until accepted, then step to the next falling edge
  task automatic send_request(logic [31:0] e, logic [31:0] d, logic v, logic c);
    error = e;
    derivative = d;
    venting = v;
    clear_integrators = c;
    item_valid = 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_sender(int n);
    item_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Let the block drain completely before touching the gains
  task automatic drain();
    item_valid = 1'b0;
    wait (pending == 0);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [23:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_gains(logic [23:0] kp, logic [23:0] ki, logic [23:0] kd,
                             logic [23:0] kph, logic [23:0] kpl, logic [23:0] kih,
                             logic [23:0] kil, logic [23:0] per);
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_KP_MULT_HI, kph);
    write_reg(REG_KP_MULT_LO, kpl);
    write_reg(REG_KI_MULT_HI, kih);
    write_reg(REG_KI_MULT_LO, kil);
    write_reg(REG_SAMPLE_PERIOD, per);
    cfg_valid = 1'b0;
  endtask

  // Random error: mostly in the scheduling band, sometimes full range
  function automatic logic [31:0] rand_error();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 32'($signed($urandom_range(0, 120 << 16)) - (60 << 16));
    if (sel < 7) return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    if (sel == 7) return 32'($signed($urandom_range(0, 2000)) - 1000);
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_derivative();
    int sel;
    sel = $urandom_range(0, 5);
    if (sel < 3) return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
    if (sel == 3) return '0;
    return $urandom;
  endfunction

  // Bursts of random requests; runs of one sign and mode build up integrators
  task automatic random_requests(int count);
    int left, burst, run, neg, vent;
    logic [31:0] e;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && left > 0) begin
        run = $urandom_range(1, 12);
        neg = $urandom_range(0, 1);
        vent = ($urandom_range(0, 9) < 3);
        while (run > 0 && burst > 0 && left > 0) begin
          e = rand_error();
          if ($urandom_range(0, 4) != 0 && ((e[31] == 1'b1) != (neg == 1)))
            e = -e;
          send_request(e, rand_derivative(),
                       ($urandom_range(0, 9) == 0) ? ~vent[0] : vent[0],
                       ($urandom_range(0, 39) == 0));
          run--; burst--; left--;
        end
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 20));
    end
  endtask

  // Limit
  initial begin
    #10ms;
    $display("gain_scheduled_pid_drive verification failed");
    $finish;
  end

  initial begin
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed corners at reset gains
    send_request(32'h7fffffff, 32'h7fffffff, 1'b0, 1'b0);
    send_request(32'h80000000, 32'h80000000, 1'b0, 1'b0);
    send_request(32'd0, 32'd0, 1'b0, 1'b0);
    send_request(32'd131072, 32'd0, 1'b0, 1'b0);
    send_request(32'd131071, 32'd0, 1'b0, 1'b0);
    send_request(32'd3276800, 32'd0, 1'b0, 1'b0);
    send_request(32'd3276801, 32'd0, 1'b0, 1'b0);
    send_request(-32'sd3276800, 32'd0, 1'b0, 1'b0);
    send_request(32'd655360, -32'sd655360, 1'b0, 1'b0);
    send_request(-32'sd655360, 32'd0, 1'b0, 1'b0);
    send_request(-32'sd655, 32'd0, 1'b1, 1'b0);
    send_request(-32'sd656, 32'd0, 1'b1, 1'b0);
    send_request(-32'sd6553600, 32'd0, 1'b1, 1'b0);
    send_request(-32'sd6553600, 32'h7fffffff, 1'b1, 1'b0);
    send_request(32'h80000000, 32'd0, 1'b1, 1'b0);
    send_request(32'd655360, 32'd0, 1'b1, 1'b0);
    send_request(32'd655360, 32'd0, 1'b0, 1'b1);
    send_request(32'd0, 32'd0, 1'b1, 1'b1);
    repeat (6) send_request(32'd3276800, 32'd0, 1'b0, 1'b0);
    drain();

    // Largest gains, then back-pressure while the sender keeps offering
    write_gains(24'hffffff, 24'hffffff, 24'hffffff, 24'hfffff, 24'hfffff,
                24'hfffff, 24'hfffff, 24'hffff);
    hold_asked++;
    random_requests(200);
    drain();

    // Zero gains and the shortest period: back-calculation is skipped
    write_gains(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd1);
    random_requests(150);
    drain();

    // Strong proportional term with no integral scale
    write_gains(24'h0a0000, 24'h0a0000, 24'd0, 24'h20000, 24'h08000,
                24'd0, 24'd0, 24'hffff);
    random_requests(150);
    drain();

    // Random gain settings
    repeat (3) begin
      write_gains(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom_range(1, 65535)));
      random_requests(150);
      drain();
    end

    // Back to the default gains
    write_gains(24'd655360, 24'd655360, 24'd327680, 24'd131072, 24'd32768,
                24'd131072, 24'd45875, 24'd6554);
    random_requests(250);

    item_valid = 1'b0;
    wait (pending == 0);
    repeat (150) @(negedge clk);
    if (fail_count == 0) begin
      $display("gain_scheduled_pid_drive verification clean");
    end else begin
      $display("gain_scheduled_pid_drive verification failed");
    end
    $finish;
  end

endmodule
